// ----- hw/rtl/pps_pkg.sv -----
`default_nettype none

package pps_pkg;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned WorkW  = 8;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = 5;

  localparam logic [TimeW-1:0] TimeMax = '1;

  // one input transaction
  typedef struct packed {
    logic             req_type;
    logic [SlotW-1:0] slot;
    logic [WorkW-1:0] burst_len;
    logic [TimeW-1:0] arrive_at;
    logic [PrioW-1:0] prio_level;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic             busy_tick;
    logic [SlotW-1:0] ran_task;
    logic             finished;
    logic [TimeW-1:0] finish_time;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] wait_time;
    logic [TimeW-1:0] now_time;
    logic             all_done;
  } res_t;

  // static part of a task slot
  typedef struct packed {
    logic [WorkW-1:0] burst;
    logic [TimeW-1:0] arrive;
    logic [PrioW-1:0] prio;
  } task_rec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pps_task_store.sv -----
`default_nettype none

module pps_task_store #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             task_we_i,
  input  wire                             work_we_i,
  input  wire [$clog2(MAX_TASKS)-1:0]     waddr_i,
  input  wire pps_pkg::task_rec_t         task_wdata_i,
  input  wire [pps_pkg::WorkW-1:0]        work_wdata_i,
  input  wire [$clog2(MAX_TASKS)-1:0]     raddr_i,
  output pps_pkg::task_rec_t              rd_task_o,
  output logic [pps_pkg::WorkW-1:0]       rd_work_o
);

  pps_pkg::task_rec_t        task_mem [MAX_TASKS];
  logic [pps_pkg::WorkW-1:0] work_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0]      vld_q;

  pps_pkg::task_rec_t        task_rd_q;
  logic [pps_pkg::WorkW-1:0] work_rd_q;
  logic                      vld_rd_q;

  // task record memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (task_we_i) begin
      task_mem[waddr_i] <= task_wdata_i;
    end
    task_rd_q <= task_mem[raddr_i];
  end

  // remaining work memory
  always_ff @(posedge clk_i) begin
    if (task_we_i || work_we_i) begin
      work_mem[waddr_i] <= work_wdata_i;
    end
    work_rd_q <= work_mem[raddr_i];
  end

  // per-slot valid bits, an unloaded slot reads as no work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (task_we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      vld_rd_q <= vld_q[raddr_i];
    end
  end

  assign rd_task_o = task_rd_q;
  assign rd_work_o = vld_rd_q ? work_rd_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/preemptive_priority_scheduler.sv -----
// channel   | ports                              | transfer
// ----------+------------------------------------+----------------------------------
// request   | start, busy, req_i                 | start high while busy low
// result    | done_o, res_o                      | done_o high for one cycle
// config    | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i and cfg_ready_o high
//
// every request scans min(task_count, MAX_TASKS) slots while busy: one slot of the
// task store is read per cycle through its single read port and checked by one
// priority comparator, then an update state and a finish state that forms the wait time.
// the result strobe comes in the same cycle as busy falls; a new start is taken then.
// reset clears time, the valid bits of the task store and the config register.
// the receiver cannot stall the result.

`default_nettype none

module preemptive_priority_scheduler #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire pps_pkg::req_t          req_i,
  output logic                        done_o,
  output pps_pkg::res_t               res_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [pps_pkg::CountW-1:0]   cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state_q, state_d;
  pps_pkg::req_t               req_q;
  logic [pps_pkg::TimeW-1:0]   clock_q, clock_d, clock_nxt;
  logic [pps_pkg::CountW-1:0]  count_q;
  logic [CW-1:0]               lim;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        rv_q, rv_d;
  logic [IW-1:0]               ridx_q;
  logic                        found_q, found_d;
  logic [IW-1:0]               best_q, best_d;
  logic [pps_pkg::PrioW-1:0]   bprio_q, bprio_d;
  logic [pps_pkg::TimeW-1:0]   barr_q, barr_d;
  logic [pps_pkg::WorkW-1:0]   bburst_q, bburst_d;
  logic [pps_pkg::WorkW-1:0]   bwork_q, bwork_d;
  logic [1:0]                  nzc_q, nzc_d;
  logic                        fin_q, fin_d;
  logic [pps_pkg::TimeW-1:0]   turn_q, turn_d;
  logic                        alld_q, alld_d;
  pps_pkg::res_t               res_q, res_d;
  logic                        done_q, done_d;

  logic                        accept;
  logic                        load_ok;
  logic                        is_tick;
  logic                        elig;
  logic                        task_we, work_we;
  logic [IW-1:0]               waddr;
  pps_pkg::task_rec_t          wrec, rd_task;
  logic [pps_pkg::WorkW-1:0]   work_wdata, rd_work;
  logic [pps_pkg::TimeW-1:0]   wait_v;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign is_tick     = (req_q.req_type == pps_pkg::REQ_TICK);

  // slots that take part
  assign lim = (32'(count_q) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(count_q);

  // load writes at acceptance, the decrement in the update cycle
  assign load_ok    = accept && (req_i.req_type == pps_pkg::REQ_LOAD)
                      && (32'(req_i.slot) < MAX_TASKS);
  assign task_we    = load_ok;
  assign work_we    = (state_q == S_UPD) && found_q;
  assign waddr      = load_ok ? IW'(req_i.slot) : best_q;
  assign wrec.burst  = req_i.burst_len;
  assign wrec.arrive = req_i.arrive_at;
  assign wrec.prio   = req_i.prio_level;
  assign work_wdata = load_ok ? req_i.burst_len : (bwork_q - 1'b1);

  pps_task_store #(
    .MAX_TASKS(MAX_TASKS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_we_i    (task_we),
    .work_we_i    (work_we),
    .waddr_i      (waddr),
    .task_wdata_i (wrec),
    .work_wdata_i (work_wdata),
    .raddr_i      (cnt_q[IW-1:0]),
    .rd_task_o    (rd_task),
    .rd_work_o    (rd_work)
  );

  // eligibility of the slot whose data came back this cycle
  assign elig = (rd_work != '0) && (rd_task.arrive <= clock_q);

  assign clock_nxt = (clock_q == pps_pkg::TimeMax) ? clock_q : (clock_q + 1'b1);
  assign wait_v    = (turn_q >= 16'(bburst_q)) ? (turn_q - 16'(bburst_q)) : '0;

  // sequencer
  always_comb begin
    state_d  = state_q;
    clock_d  = clock_q;
    cnt_d    = cnt_q;
    rv_d     = 1'b0;
    found_d  = found_q;
    best_d   = best_q;
    bprio_d  = bprio_q;
    barr_d   = barr_q;
    bburst_d = bburst_q;
    bwork_d  = bwork_q;
    nzc_d    = nzc_q;
    fin_d    = fin_q;
    turn_d   = turn_q;
    alld_d   = alld_q;
    res_d    = res_q;
    done_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          found_d = 1'b0;
          nzc_d   = '0;
        end
      end
      S_SCAN: begin
        // issue the next read, move on once the last slot is checked
        if (cnt_q < lim) begin
          rv_d  = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = S_UPD;
        end
        // check the slot read last cycle
        if (rv_q) begin
          if (rd_work != '0 && nzc_q != 2'd2) begin
            nzc_d = nzc_q + 1'b1;
          end
          if (is_tick && elig && (!found_q || rd_task.prio > bprio_q)) begin
            found_d  = 1'b1;
            best_d   = ridx_q;
            bprio_d  = rd_task.prio;
            barr_d   = rd_task.arrive;
            bburst_d = rd_task.burst;
            bwork_d  = rd_work;
          end
        end
      end
      S_UPD: begin
        if (is_tick) begin
          clock_d = clock_nxt;
        end
        fin_d  = found_q && (bwork_q == 8'd1);
        turn_d = (clock_nxt >= barr_q) ? (clock_nxt - barr_q) : '0;
        alld_d = (nzc_q == 2'd0)
                 || ((nzc_q == 2'd1) && found_q && (bwork_q == 8'd1));
        state_d = S_FIN;
      end
      S_FIN: begin
        res_d.busy_tick   = found_q;
        res_d.ran_task    = found_q ? 4'(best_q) : '0;
        res_d.finished    = fin_q;
        res_d.finish_time = fin_q ? clock_q : '0;
        res_d.turnaround  = fin_q ? turn_q : '0;
        res_d.wait_time   = fin_q ? wait_v : '0;
        res_d.now_time    = clock_q;
        res_d.all_done    = alld_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      clock_q <= '0;
      count_q <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clock_q <= clock_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    ridx_q   <= cnt_q[IW-1:0];
    best_q   <= best_d;
    bprio_q  <= bprio_d;
    barr_q   <= barr_d;
    bburst_q <= bburst_d;
    bwork_q  <= bwork_d;
    nzc_q    <= nzc_d;
    fin_q    <= fin_d;
    turn_q   <= turn_d;
    alld_q   <= alld_d;
    res_q    <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FIN))
    else $error("result strobe without a finish cycle");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_UPD) && found_q) |-> (32'(best_q) < 32'(lim)))
    else $error("selected slot outside the active range");

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_UPD) |=> (clock_q == $past(clock_q)))
    else $error("time moved outside the update cycle");

endmodule

`default_nettype wire

// ----- tb/preemptive_priority_scheduler_test.sv -----
module preemptive_priority_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  pps_pkg::req_t              req_i;
  logic                       done_o;
  pps_pkg::res_t              res_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [pps_pkg::CountW-1:0] cfg_data_i;

  // mirror of the scheduler state
  logic [pps_pkg::CountW-1:0] task_count_q;
  logic [pps_pkg::TimeW-1:0]  clock_q;
  logic [pps_pkg::WorkW-1:0]  remaining [SLOTS];
  pps_pkg::task_rec_t         slot_rec [SLOTS];
  pps_pkg::res_t              expected_q [$];

  int unsigned n_errors = 0;
  int unsigned n_loads = 0;
  int unsigned n_ticks = 0;
  int unsigned n_finished = 0;
  int unsigned n_cfg = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;

  preemptive_priority_scheduler #(
    .MAX_TASKS(SLOTS)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .done_o,
    .res_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one request applied to the mirror, returns the result it should give
  function automatic pps_pkg::res_t schedule_step(pps_pkg::req_t r);
    pps_pkg::res_t             o;
    int unsigned               lim;
    int unsigned               best;
    int unsigned               i;
    bit                        found;
    logic [pps_pkg::TimeW-1:0] turn;
    o = '0;
    lim = (task_count_q > SLOTS) ? SLOTS : task_count_q;
    if (r.req_type == pps_pkg::REQ_LOAD) begin
      slot_rec[r.slot] = '{burst: r.burst_len, arrive: r.arrive_at, prio: r.prio_level};
      remaining[r.slot] = r.burst_len;
    end else begin
      found = 1'b0;
      best = 0;
      // highest priority among arrived slots with work, lowest slot on a tie
      for (i = 0; i < lim; i++) begin
        if (remaining[i] != '0 && slot_rec[i].arrive <= clock_q &&
            (!found || slot_rec[i].prio > slot_rec[best].prio)) begin
          best = i;
          found = 1'b1;
        end
      end
      if (clock_q != pps_pkg::TimeMax) clock_q = clock_q + 1'b1;
      if (found) begin
        o.busy_tick = 1'b1;
        o.ran_task = best[pps_pkg::SlotW-1:0];
        remaining[best] = remaining[best] - 1'b1;
        if (remaining[best] == '0) begin
          o.finished = 1'b1;
          o.finish_time = clock_q;
          turn = (clock_q >= slot_rec[best].arrive) ? clock_q - slot_rec[best].arrive : '0;
          o.turnaround = turn;
          o.wait_time = (turn >= slot_rec[best].burst) ? turn - slot_rec[best].burst : '0;
        end
      end
    end
    o.now_time = clock_q;
    o.all_done = 1'b1;
    for (i = 0; i < lim; i++) begin
      if (remaining[i] != '0) o.all_done = 1'b0;
    end
    return o;
  endfunction

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int unsigned gap_len();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic pps_pkg::req_t load_item(int unsigned slot, int unsigned burst,
                                              int unsigned arrive, int unsigned prio);
    pps_pkg::req_t r;
    r.req_type = pps_pkg::REQ_LOAD;
    r.slot = slot[pps_pkg::SlotW-1:0];
    r.burst_len = burst[pps_pkg::WorkW-1:0];
    r.arrive_at = arrive[pps_pkg::TimeW-1:0];
    r.prio_level = prio[pps_pkg::PrioW-1:0];
    return r;
  endfunction

  // tick with random contents in the fields it ignores
  function automatic pps_pkg::req_t random_tick();
    logic [63:0]   raw;
    pps_pkg::req_t r;
    raw = {$urandom, $urandom};
    r = raw[$bits(pps_pkg::req_t)-1:0];
    r.req_type = pps_pkg::REQ_TICK;
    return r;
  endfunction

  // load aimed mostly at active slots, arriving around the current time
  function automatic pps_pkg::req_t random_load();
    int unsigned lim;
    int unsigned slot;
    int unsigned burst;
    int unsigned arrive;
    int unsigned prio;
    lim = (task_count_q == 0) ? 1 : ((task_count_q > SLOTS) ? SLOTS : task_count_q);
    slot = ($urandom_range(3) != 0) ? $urandom_range(lim - 1) : $urandom_range(SLOTS - 1);
    case ($urandom_range(9))
      0: burst = 0;
      1: burst = $urandom_range(255);
      2, 3: burst = $urandom_range(40, 7);
      default: burst = $urandom_range(6, 1);
    endcase
    case ($urandom_range(9))
      0: arrive = $urandom_range(65535);
      1: arrive = $urandom_range(clock_q);
      default: arrive = clock_q + $urandom_range(12);
    endcase
    prio = ($urandom_range(1) != 0) ? $urandom_range(3) : $urandom_range(255);
    return load_item(slot, burst, arrive, prio);
  endfunction

  // send one request, record its expected result on acceptance
  task automatic send_req(pps_pkg::req_t r);
    int unsigned gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(schedule_step(r));
    if (r.req_type == pps_pkg::REQ_LOAD) n_loads++;
    else n_ticks++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_task_count(logic [pps_pkg::CountW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    task_count_q = value;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("t=%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    pps_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("t=%0t: unexpected result transaction, expected none, actual %h",
                 $time, res_o);
      end else begin
        want = expected_q.pop_front();
        check_field("busy_tick", 16'(want.busy_tick), 16'(res_o.busy_tick));
        check_field("ran_task", 16'(want.ran_task), 16'(res_o.ran_task));
        check_field("finished", 16'(want.finished), 16'(res_o.finished));
        check_field("finish_time", want.finish_time, res_o.finish_time);
        check_field("turnaround", want.turnaround, res_o.turnaround);
        check_field("wait_time", want.wait_time, res_o.wait_time);
        check_field("now_time", want.now_time, res_o.now_time);
        check_field("all_done", 16'(want.all_done), 16'(res_o.all_done));
        if (want.finished) n_finished++;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ticks with no slots taking part only advance time
  task automatic test_idle_ticks();
    send_req(random_tick());
    send_req(random_tick());
  endtask

  // preemption, tie on priority, zero burst, slot outside the count
  task automatic test_priority_order();
    write_task_count(5'd4);
    send_req(load_item(0, 2, 0, 5));
    send_req(load_item(3, 1, 0, 5));
    send_req(load_item(2, 0, 0, 255));
    send_req(load_item(1, 1, clock_q + 1, 9));
    send_req(load_item(15, 255, 65535, 255));
    repeat (5) send_req(random_tick());
  endtask

  // reload of a slot while its task is running
  task automatic test_reload_running();
    send_req(load_item(0, 3, 0, 0));
    send_req(random_tick());
    send_req(load_item(0, 1, clock_q, 0));
    send_req(random_tick());
  endtask

  // a count above the slot total acts as all slots
  task automatic test_oversized_count();
    write_task_count(5'd31);
    send_req(random_tick());
    send_req(random_tick());
  endtask

  // load bursts followed by runs of ticks, with some raw noise
  task automatic test_random_mix();
    logic [pps_pkg::CountW-1:0] counts [8];
    logic [63:0]                raw;
    pps_pkg::req_t              noise;
    int unsigned                p;
    int unsigned                sent;
    counts = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd7, 5'd0, 5'd17, 5'd12};
    for (p = 0; p < 8; p++) begin
      write_task_count(counts[p]);
      sent = 0;
      while (sent < 180) begin
        if ($urandom_range(7) == 0) no_gaps = !no_gaps;
        if ($urandom_range(49) == 0) drain_results();
        if ($urandom_range(9) == 0) begin
          raw = {$urandom, $urandom};
          noise = raw[$bits(pps_pkg::req_t)-1:0];
          send_req(noise);
          sent++;
        end else begin
          repeat ($urandom_range(3, 1)) begin
            send_req(random_load());
            sent++;
          end
          repeat ($urandom_range(12, 1)) begin
            send_req(random_tick());
            sent++;
          end
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // every slot cleared, then tasks arriving ahead of time finish with waits
  task automatic test_late_arrivals();
    int unsigned s;
    write_task_count(5'd16);
    for (s = 0; s < SLOTS; s++) send_req(load_item(s, 0, $urandom_range(65535),
                                                   $urandom_range(255)));
    send_req(load_item(3, 4, clock_q + 2, 200));
    send_req(load_item(4, 2, clock_q + 6, 255));
    send_req(load_item(5, 3, 0, 1));
    repeat (12) send_req(random_tick());
  endtask

  initial begin
    int unsigned s;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    task_count_q = '0;
    clock_q = '0;
    for (s = 0; s < SLOTS; s++) begin
      remaining[s] = '0;
      slot_rec[s] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_ticks();
    test_priority_order();
    test_reload_running();
    test_oversized_count();
    test_random_mix();
    test_late_arrivals();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("ran %0d loads and %0d ticks over %0d task_count settings, %0d completions",
             n_loads, n_ticks, n_cfg, n_finished);
    $display("time driven to %0d, mismatches and stray results: %0d", clock_q, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- preemptive_priority_scheduler.f -----
hw/rtl/pps_pkg.sv
hw/rtl/pps_task_store.sv
hw/rtl/preemptive_priority_scheduler.sv
tb/preemptive_priority_scheduler_test.sv
